/* src/cft_pkg.sv */
package cft_pkg;

    // Table geometry
    localparam int NUM_BUCKETS = 1024;
    localparam int SLOTS       = 4;
    localparam int FP_BITS     = 8;

    localparam int IDX_W  = $clog2(NUM_BUCKETS);
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORD_W = SLOTS * FP_BITS;

    // Widths of the word fields
    localparam int ACTION_W = 2;
    localparam int BUCKET_W = 10;
    localparam int MASK_W   = 8;
    localparam int LFSR_W   = 16;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [MASK_W-1:0] MASK_RESET = 8'hFF;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BUCKET_W-1:0] bucket_a;
        logic [BUCKET_W-1:0] bucket_b;
        logic                use_both;
        logic [FP_BITS-1:0]  fingerprint;
        logic                evict_enable;
    } req_word_t;

    typedef struct packed {
        logic               success;
        logic [FP_BITS-1:0] evicted_fp;
        logic               evicted_valid;
    } rsp_word_t;

endpackage

/* src/cuckoo_filter_bucket_table.sv */
// Bucket table of a cuckoo filter: NUM_BUCKETS buckets of SLOTS fingerprint
// slots, held in one bucket-wide synchronous memory, zero meaning empty.
// Each request (insert, lookup, delete) returns exactly one response word.
// A request is read in the idle state, buckets A and B from the memory's two
// read ports, and finished in the execute state, which decides, writes the
// bucket back and loads the response register; the single read-modify-write
// on the memory means no new request is taken until the last one is written
// back, and the execute state waits while the response register is held.
// After reset the memory is swept to zero, one bucket a cycle, and no request
// is taken until that ends; fingerprint_mask writes are taken at any time.
module cuckoo_filter_bucket_table
    import cft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  req_word_t         in_data,

    output logic              out_valid,
    input  logic              out_stall,
    output rsp_word_t         out_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [MASK_W-1:0] fp_mask_reg;
    logic [LFSR_W-1:0] lfsr_reg;
    req_word_t         req_reg;
    logic              out_valid_reg;
    rsp_word_t         out_data_reg;

    logic [WORD_W-1:0] bucket_mem [NUM_BUCKETS];
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;

    logic              in_take;
    logic              exec_go;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic [FP_BITS-1:0] slot_mask;
    logic [LFSR_W-1:0]  lfsr_adv;
    logic [SLOT_W-1:0]  victim;
    logic               lfsr_step;
    rsp_word_t          rsp;
    logic               wb_en;
    logic               wb_sel_b;
    logic [WORD_W-1:0]  wb_word;

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && (state_reg == ST_IDLE);
    assign exec_go   = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign slot_mask = fp_mask_reg[FP_BITS-1:0];

    // victim LFSR, x^16 + x^14 + x^13 + x^11 + 1
    assign lfsr_adv = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                       lfsr_reg[LFSR_W-1:1]};
    assign victim   = SLOT_W'(lfsr_adv % SLOTS);

    // decide the action on the buckets just read
    always_comb
    begin
        logic               found;
        logic [SLOT_W-1:0]  hit_idx;
        logic [FP_BITS-1:0] a_slot;
        logic [FP_BITS-1:0] b_slot;

        found     = 1'b0;
        hit_idx   = '0;
        a_slot    = '0;
        b_slot    = '0;
        wb_sel_b  = 1'b0;
        wb_en     = 1'b0;
        wb_word   = rd_a_reg;
        lfsr_step = 1'b0;
        rsp       = '0;

        unique case (req_reg.action)
            ACT_INSERT:
            begin
                // lowest slot that reads empty
                for (int s = 0; s < SLOTS; s++)
                begin
                    a_slot = rd_a_reg[s*FP_BITS +: FP_BITS] & slot_mask;
                    if (!found && a_slot == '0)
                    begin
                        found   = 1'b1;
                        hit_idx = SLOT_W'(s);
                    end
                end
                if (found)
                begin
                    wb_en = 1'b1;
                    wb_word[hit_idx*FP_BITS +: FP_BITS] = req_reg.fingerprint & slot_mask;
                    rsp.success = 1'b1;
                end
                else if (req_reg.evict_enable)
                begin
                    wb_en     = 1'b1;
                    lfsr_step = 1'b1;
                    wb_word[victim*FP_BITS +: FP_BITS] = req_reg.fingerprint & slot_mask;
                    rsp.evicted_fp    = rd_a_reg[victim*FP_BITS +: FP_BITS] & slot_mask;
                    rsp.evicted_valid = 1'b1;
                end
            end
            ACT_LOOKUP:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    a_slot = rd_a_reg[s*FP_BITS +: FP_BITS] & slot_mask;
                    b_slot = rd_b_reg[s*FP_BITS +: FP_BITS] & slot_mask;
                    if (a_slot == req_reg.fingerprint ||
                        (req_reg.use_both && b_slot == req_reg.fingerprint))
                        found = 1'b1;
                end
                rsp.success = found;
            end
            ACT_DELETE:
            begin
                // order A0, B0, A1, B1, ...
                for (int s = 0; s < SLOTS; s++)
                begin
                    a_slot = rd_a_reg[s*FP_BITS +: FP_BITS] & slot_mask;
                    b_slot = rd_b_reg[s*FP_BITS +: FP_BITS] & slot_mask;
                    if (!found)
                    begin
                        if (a_slot == req_reg.fingerprint)
                        begin
                            found    = 1'b1;
                            hit_idx  = SLOT_W'(s);
                            wb_sel_b = 1'b0;
                        end
                        else if (req_reg.use_both && b_slot == req_reg.fingerprint)
                        begin
                            found    = 1'b1;
                            hit_idx  = SLOT_W'(s);
                            wb_sel_b = 1'b1;
                        end
                    end
                end
                if (found)
                begin
                    wb_en   = 1'b1;
                    wb_word = wb_sel_b ? rd_b_reg : rd_a_reg;
                    wb_word[hit_idx*FP_BITS +: FP_BITS] = '0;
                end
                rsp.success = found;
            end
            default:
            begin
                // unused code: no change, all fields zero
            end
        endcase
    end

    // memory write port: clearing sweep or write-back
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = exec_go && wb_en;
            mem_waddr = wb_sel_b ? req_reg.bucket_b[IDX_W-1:0]
                                 : req_reg.bucket_a[IDX_W-1:0];
            mem_wdata = wb_word;
        end
    end

    // bucket memory, one write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bucket_mem[mem_waddr] <= mem_wdata;
        if (in_take)
        begin
            rd_a_reg <= bucket_mem[in_data.bucket_a[IDX_W-1:0]];
            rd_b_reg <= bucket_mem[in_data.bucket_b[IDX_W-1:0]];
        end
    end

    // request word held for the execute cycle
    always_ff @(posedge clk)
    begin
        if (in_take)
            req_reg <= in_data;
    end

    // mask register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fp_mask_reg <= MASK_RESET;
        else if (cfg_wr_en)
            fp_mask_reg <= cfg_wr_data;
    end

    // sequencer, LFSR and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            lfsr_reg      <= LFSR_SEED;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // response register: loaded on execute, freed when taken
            if (exec_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == IDX_W'(NUM_BUCKETS - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (in_take)
                        state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (exec_go)
                    begin
                        out_data_reg <= rsp;
                        if (lfsr_step)
                            lfsr_reg <= lfsr_adv;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/sv/cuckoo_filter_bucket_table_tb.sv */
module cuckoo_filter_bucket_table_tb;
    import cft_pkg::*;

    // Action code with no meaning; the block must leave everything alone
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Run limit: far beyond the slowest correct run, including the sweep
    localparam int LIMIT_CYCLES = 400000;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_WORDS  = 140;

    // Mirror of the bucket table: slots, victim LFSR, mask, owed responses
    class bucket_table_model;
        logic [FP_BITS-1:0] slot_val [NUM_BUCKETS][SLOTS];
        logic [LFSR_W-1:0]  victim_lfsr;
        logic [MASK_W-1:0]  fp_mask;
        rsp_word_t          owed_responses [$];
        int                 errors;

        function new();
            for (int b = 0; b < NUM_BUCKETS; b++)
                for (int s = 0; s < SLOTS; s++)
                    slot_val[b][s] = '0;
            victim_lfsr = LFSR_SEED;
            fp_mask     = MASK_RESET;
            errors      = 0;
        endfunction

        function void set_mask(logic [MASK_W-1:0] m);
            fp_mask = m;
        endfunction

        function int pending();
            return owed_responses.size();
        endfunction

        // Work out the response to one accepted request and update the table
        function void note_request(req_word_t r);
            rsp_word_t          rsp;
            logic [FP_BITS-1:0] m;
            int                 ba;
            int                 bb;
            int                 victim;
            rsp = '0;
            m   = FP_BITS'(fp_mask);
            ba  = int'(r.bucket_a) % NUM_BUCKETS;
            bb  = int'(r.bucket_b) % NUM_BUCKETS;
            case (r.action)
                ACT_INSERT:
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (!rsp.success && (slot_val[ba][s] & m) == '0)
                        begin
                            slot_val[ba][s] = r.fingerprint & m;
                            rsp.success     = 1'b1;
                        end
                    end
                    if (!rsp.success && r.evict_enable)
                    begin
                        victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3]
                                       ^ victim_lfsr[5], victim_lfsr[LFSR_W-1:1]};
                        victim = int'(victim_lfsr) % SLOTS;
                        rsp.evicted_fp      = slot_val[ba][victim] & m;
                        rsp.evicted_valid   = 1'b1;
                        slot_val[ba][victim] = r.fingerprint & m;
                    end
                end
                ACT_LOOKUP:
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if ((slot_val[ba][s] & m) == r.fingerprint)
                            rsp.success = 1'b1;
                        if (r.use_both && (slot_val[bb][s] & m) == r.fingerprint)
                            rsp.success = 1'b1;
                    end
                end
                ACT_DELETE:
                begin
                    // interleaved A0, B0, A1, B1 ... first match cleared
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (!rsp.success)
                        begin
                            if ((slot_val[ba][s] & m) == r.fingerprint)
                            begin
                                slot_val[ba][s] = '0;
                                rsp.success     = 1'b1;
                            end
                            else if (r.use_both && (slot_val[bb][s] & m) == r.fingerprint)
                            begin
                                slot_val[bb][s] = '0;
                                rsp.success     = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            owed_responses.push_back(rsp);
        endfunction

        // Compare one accepted response word with the oldest owed one
        function void check_response(rsp_word_t got);
            rsp_word_t want;
            if (owed_responses.size() == 0)
            begin
                $error("response word with no request outstanding");
                errors++;
                return;
            end
            want = owed_responses.pop_front();
            if (got.success !== want.success)
            begin
                $error("success: expected %0d, got %0d", want.success, got.success);
                errors++;
            end
            if (got.evicted_fp !== want.evicted_fp)
            begin
                $error("evicted_fp: expected 0x%02h, got 0x%02h",
                       want.evicted_fp, got.evicted_fp);
                errors++;
            end
            if (got.evicted_valid !== want.evicted_valid)
            begin
                $error("evicted_valid: expected %0d, got %0d",
                       want.evicted_valid, got.evicted_valid);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [MASK_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    req_word_t         in_data;
    logic              out_valid;
    logic              out_stall;
    rsp_word_t         out_data;

    bucket_table_model  table_model;
    bit                 quiet;
    logic [FP_BITS-1:0] recent_fps [$];

    cuckoo_filter_bucket_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hang guard
    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("cuckoo_filter_bucket_table_tb: errors");
        $finish;
    end

    // Response side: check accepted words, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            table_model.check_response(out_data);
        out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 21);
    end

    // Offer one request word, hold it until taken, then maybe idle a while
    task automatic send_request(input req_word_t r);
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall);
        table_model.note_request(r);
        if (r.action == ACT_INSERT)
        begin
            recent_fps.push_back(r.fingerprint);
            if (recent_fps.size() > 16)
                void'(recent_fps.pop_front());
        end
        while (!quiet && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_fields(input logic [ACTION_W-1:0] act, input int ba, input int bb,
                               input int both, input int fp, input int ev);
        req_word_t r;
        r.action       = act;
        r.bucket_a     = BUCKET_W'(ba);
        r.bucket_b     = BUCKET_W'(bb);
        r.use_both     = 1'(both);
        r.fingerprint  = FP_BITS'(fp);
        r.evict_enable = 1'(ev);
        send_request(r);
    endtask

    // Hold off until every owed response is back
    task automatic drain;
        in_valid <= 1'b0;
        while (table_model.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        table_model.set_mask(m);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly a handful of hot buckets so they fill and evict
    function automatic logic [BUCKET_W-1:0] pick_bucket();
        if ($urandom_range(0, 99) < 70)
            return BUCKET_W'($urandom_range(0, 5));
        return BUCKET_W'($urandom_range(0, NUM_BUCKETS - 1));
    endfunction

    function automatic req_word_t random_request();
        req_word_t r;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.action = ACT_INSERT;
        else if (pick < 65)
            r.action = ACT_LOOKUP;
        else if (pick < 95)
            r.action = ACT_DELETE;
        else
            r.action = ACT_UNUSED;
        r.bucket_a = pick_bucket();
        r.bucket_b = ($urandom_range(0, 9) == 0) ? r.bucket_a : pick_bucket();
        r.use_both = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 60 && recent_fps.size() > 0)
            r.fingerprint = recent_fps[$urandom_range(0, recent_fps.size() - 1)];
        else if (pick < 65)
            r.fingerprint = '0;
        else
            r.fingerprint = FP_BITS'($urandom_range(0, 255));
        r.evict_enable = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Stimulus
    initial
    begin
        table_model = new();
        quiet       = 1'b0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mask(MASK_RESET);

        // fill bucket 0, then full without and with eviction
        send_fields(ACT_INSERT, 0, 0, 0, 8'h11, 0);
        send_fields(ACT_INSERT, 0, 0, 0, 8'h22, 0);
        send_fields(ACT_INSERT, 0, 0, 0, 8'h33, 0);
        send_fields(ACT_INSERT, 0, 0, 0, 8'h44, 0);
        send_fields(ACT_INSERT, 0, 0, 0, 8'h55, 0);
        send_fields(ACT_INSERT, 0, 0, 0, 8'h66, 1);
        // lookups: hit in A, hit via B, miss without B, zero on empty
        send_fields(ACT_LOOKUP, 0, 0, 0, 8'h22, 0);
        send_fields(ACT_LOOKUP, 1, 0, 1, 8'h33, 0);
        send_fields(ACT_LOOKUP, 1, 0, 0, 8'h33, 0);
        send_fields(ACT_LOOKUP, 1023, 1023, 0, 8'h00, 0);
        // deletes: zero on empty, from B, same bucket twice, miss
        send_fields(ACT_DELETE, 1023, 0, 0, 8'h00, 0);
        send_fields(ACT_DELETE, 1, 0, 1, 8'h44, 0);
        send_fields(ACT_DELETE, 0, 0, 1, 8'h22, 0);
        send_fields(ACT_DELETE, 0, 0, 0, 8'h99, 1);
        // top bucket: fill and evict repeatedly
        send_fields(ACT_INSERT, 1023, 1023, 1, 8'hFF, 1);
        send_fields(ACT_INSERT, 1023, 1023, 1, 8'hFE, 1);
        send_fields(ACT_INSERT, 1023, 1023, 1, 8'h80, 1);
        send_fields(ACT_INSERT, 1023, 1023, 1, 8'h01, 1);
        send_fields(ACT_INSERT, 1023, 1023, 1, 8'hAA, 1);
        send_fields(ACT_INSERT, 1023, 1023, 1, 8'h55, 1);
        send_fields(ACT_INSERT, 1023, 1023, 1, 8'hC3, 1);
        // zero fingerprint insert, unused code with every field high
        send_fields(ACT_INSERT, 2, 2, 0, 8'h00, 0);
        send_fields(ACT_UNUSED, 1023, 1023, 1, 8'hFF, 1);
        send_fields(ACT_LOOKUP, 1023, 0, 1, 8'hAA, 0);

        // random phases, one mask setting each, drained between
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p)
                0:       write_mask(8'hFF);
                1:       write_mask(8'h0F);
                2:       write_mask(8'h00);
                3:       write_mask(MASK_W'($urandom_range(1, 254)));
                default: write_mask(8'hF0);
            endcase
            quiet = (p == 0);
            for (int i = 0; i < PHASE_WORDS; i++)
                send_request(random_request());
            quiet = 1'b0;
        end

        drain();
        repeat (20) @(posedge clk);
        if (table_model.errors == 0 && table_model.pending() == 0)
            $display("cuckoo_filter_bucket_table_tb: clean");
        else
            $display("cuckoo_filter_bucket_table_tb: errors");
        $finish;
    end

endmodule
